### design/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Types and constants shared by the button event classifier.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLED_MASK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LEVELS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_TICKS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_TICKS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COMBO_WINDOW  = 3'd5;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST  = 16'd15;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST   = 16'd100;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd250;
    localparam logic [TICK_W-1:0] COMBO_WINDOW_RST = 16'd15;
    localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DOWN  = 2'd1,
        ST_COMBO = 2'd2
    } t_stage;

    typedef enum logic [3:0] {
        EV_DOWN     = 4'd0,
        EV_CLICK    = 4'd1,
        EV_SHORT    = 4'd2,
        EV_SHORT_UP = 4'd3,
        EV_LONG     = 4'd4,
        EV_LONG_UP  = 4'd5,
        EV_HOLD     = 4'd6,
        EV_HOLD_UP  = 4'd7,
        EV_RELEASE  = 4'd8,
        EV_NONE     = 4'd9
    } t_event;

    typedef struct packed {
        logic [7:0] pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [2:0] button_number;
        logic [3:0] event_code;
        logic [1:0] click_count;
        logic       last_of_tick;
    } t_out_item;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [TICK_W-1:0]    reg_value;
    } t_cfg_item;

    typedef struct packed {
        logic [7:0]        enabled_mask;
        logic [7:0]        active_levels;
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] combo_window;
    } t_cfg;

endpackage

### design/bec_chan_if.sv
// ----------------------------------------------------------------------------
// bec_chan_if
// Valid/ready channel carrying one item of a generic payload type.
// ----------------------------------------------------------------------------
interface bec_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/bec_ram.sv
// ----------------------------------------------------------------------------
// bec_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bec_cfg_regs.sv
// ----------------------------------------------------------------------------
// bec_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module bec_cfg_regs
    import bec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bec_chan_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                REG_ENABLED_MASK:  n_cfg.enabled_mask  = i_cfg.data.reg_value[7:0];
                REG_ACTIVE_LEVELS: n_cfg.active_levels = i_cfg.data.reg_value[7:0];
                REG_SHORT_TICKS:   n_cfg.short_ticks   = i_cfg.data.reg_value;
                REG_LONG_TICKS:    n_cfg.long_ticks    = i_cfg.data.reg_value;
                REG_HOLD_TICKS:    n_cfg.hold_ticks    = i_cfg.data.reg_value;
                REG_COMBO_WINDOW:  n_cfg.combo_window  = i_cfg.data.reg_value;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled_mask  <= '0;
            r_cfg.active_levels <= '0;
            r_cfg.short_ticks   <= SHORT_TICKS_RST;
            r_cfg.long_ticks    <= LONG_TICKS_RST;
            r_cfg.hold_ticks    <= HOLD_TICKS_RST;
            r_cfg.combo_window  <= COMBO_WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### design/bec_button_unit.sv
// ----------------------------------------------------------------------------
// bec_button_unit
// Next-state and event logic for one button over one scan tick.
// ----------------------------------------------------------------------------
module bec_button_unit
    import bec_pkg::*;
#(
    parameter int unsigned CLICK_CAP = 3,
    localparam int unsigned CW = $clog2(CLICK_CAP + 1)
) (
    input  t_cfg              i_cfg,
    input  logic              i_pressed,
    input  t_stage            i_stage,
    input  logic [TICK_W-1:0] i_tick,
    input  logic [CW-1:0]     i_clicks,
    input  t_event            i_last,
    output t_stage            o_stage,
    output logic [TICK_W-1:0] o_tick,
    output logic [CW-1:0]     o_clicks,
    output t_event            o_last,
    output logic              o_ev_valid,
    output t_event            o_ev_code,
    output logic [1:0]        o_ev_count
);

    logic [TICK_W-1:0] w_t;
    t_event            w_ev;
    logic [CW-1:0]     w_count;

    always_comb begin
        w_t      = i_tick;
        w_ev     = EV_NONE;
        w_count  = '0;
        o_stage  = i_stage;
        o_clicks = i_clicks;

        if ((i_stage == ST_DOWN || i_stage == ST_COMBO) && i_tick != TICK_MAX) begin
            w_t = i_tick + 1'b1;
        end
        o_tick = w_t;

        case (i_stage)
            ST_DOWN: begin
                if (i_pressed) begin
                    if (i_clicks != '0) begin
                        if (w_t > i_cfg.combo_window) begin
                            w_ev     = EV_CLICK;
                            w_count  = i_clicks;
                            o_tick   = '0;
                            o_clicks = '0;
                        end
                    end else if (w_t >= i_cfg.hold_ticks) begin
                        if (i_last != EV_HOLD) w_ev = EV_HOLD;
                    end else if (w_t >= i_cfg.long_ticks) begin
                        if (i_last != EV_LONG) w_ev = EV_LONG;
                    end else if (w_t >= i_cfg.short_ticks) begin
                        if (i_last != EV_SHORT) w_ev = EV_SHORT;
                    end
                end else begin
                    if (w_t >= i_cfg.hold_ticks) begin
                        w_ev    = EV_HOLD_UP;
                        o_stage = ST_IDLE;
                    end else if (w_t >= i_cfg.long_ticks) begin
                        w_ev    = EV_LONG_UP;
                        o_stage = ST_IDLE;
                    end else if (w_t >= i_cfg.short_ticks) begin
                        w_ev    = EV_SHORT_UP;
                        o_stage = ST_IDLE;
                    end else begin
                        o_stage = ST_COMBO;
                        if (i_clicks < CW'(CLICK_CAP)) o_clicks = i_clicks + 1'b1;
                        w_ev = EV_RELEASE;
                    end
                end
            end
            ST_COMBO: begin
                if (i_pressed) begin
                    o_stage = ST_DOWN;
                    o_tick  = '0;
                end else if (w_t > i_cfg.combo_window) begin
                    w_ev    = EV_CLICK;
                    w_count = i_clicks;
                    o_stage = ST_IDLE;
                end
            end
            default: begin
                o_tick = '0;
                if (i_pressed) begin
                    o_clicks = '0;
                    w_ev     = EV_DOWN;
                    o_stage  = ST_DOWN;
                end
            end
        endcase

        o_last     = (w_ev != EV_NONE) ? w_ev : i_last;
        o_ev_valid = (w_ev != EV_NONE);
        o_ev_code  = w_ev;
        o_ev_count = 2'(w_count);
    end

endmodule

### design/button_event_classifier.sv
// ----------------------------------------------------------------------------
// button_event_classifier
// Scans the buttons of one tick through a shared unit and reports their events.
// ----------------------------------------------------------------------------
//   port    dir  payload                                         role
//   i_in    in   pin_levels                                      scan tick
//   o_out   out  button_number, event_code, click_count, last    event
//   i_cfg   in   reg_index, reg_value                            register write
//
// A tick is accepted in S_IDLE, each button then goes through the read-modify-write
// of the state RAM in S_RUN, and S_FLUSH releases the last event.
// An event that finds both the pending register and the output register full
// stalls the scan for every cycle until the output register frees.
// Reset clears the entry valid bits, so every button reads as idle afterwards.
// A new tick is taken only after the previous one has been fully scanned.
// ----------------------------------------------------------------------------
module button_event_classifier
    import bec_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 8,
    parameter int unsigned CLICK_CAP   = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bec_chan_if.sink    i_in,
    bec_chan_if.source  o_out,
    bec_chan_if.sink    i_cfg
);

    localparam int unsigned IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int unsigned CW = $clog2(CLICK_CAP + 1);
    localparam int unsigned SW = 2 + TICK_W + CW + 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } t_fsm;

    t_cfg w_cfg;

    t_fsm                   r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic [7:0]             r_pins, n_pins;
    logic [NUM_BUTTONS-1:0] r_valid, n_valid;
    logic                   r_hold_valid, n_hold_valid;
    t_out_item              r_hold, n_hold;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [IW-1:0] w_raddr;
    logic [SW-1:0] w_rdata;
    logic [SW-1:0] w_wdata;
    logic          w_we;

    t_stage            w_stage_in, w_stage_out;
    logic [TICK_W-1:0] w_tick_in, w_tick_out;
    logic [CW-1:0]     w_clicks_in, w_clicks_out;
    t_event            w_last_in, w_last_out;
    logic              w_ev_valid;
    t_event            w_ev_code;
    logic [1:0]        w_ev_count;

    logic w_en;
    logic w_pressed;
    logic w_out_free;
    logic w_stall;
    logic w_push;
    logic w_is_last;

    bec_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bec_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_valid[r_idx]) begin
            w_stage_in  = t_stage'(w_rdata[SW-1 -: 2]);
            w_tick_in   = w_rdata[SW-3 -: TICK_W];
            w_clicks_in = w_rdata[4 +: CW];
            w_last_in   = t_event'(w_rdata[3:0]);
        end else begin
            w_stage_in  = ST_IDLE;
            w_tick_in   = '0;
            w_clicks_in = '0;
            w_last_in   = EV_NONE;
        end
    end

    assign w_en      = (int'(r_idx) < 8) && w_cfg.enabled_mask[3'(r_idx)];
    assign w_pressed = !(r_pins[3'(r_idx)] ^ w_cfg.active_levels[3'(r_idx)]);

    bec_button_unit #(
        .CLICK_CAP (CLICK_CAP)
    ) u_unit (
        .i_cfg      (w_cfg),
        .i_pressed  (w_pressed),
        .i_stage    (w_stage_in),
        .i_tick     (w_tick_in),
        .i_clicks   (w_clicks_in),
        .i_last     (w_last_in),
        .o_stage    (w_stage_out),
        .o_tick     (w_tick_out),
        .o_clicks   (w_clicks_out),
        .o_last     (w_last_out),
        .o_ev_valid (w_ev_valid),
        .o_ev_code  (w_ev_code),
        .o_ev_count (w_ev_count)
    );

    assign w_wdata    = {w_stage_out, w_tick_out, w_clicks_out, w_last_out};
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_stall    = (r_state == S_RUN) && w_en && w_ev_valid && r_hold_valid
                        && !w_out_free;
    assign w_is_last  = (r_idx == IW'(NUM_BUTTONS - 1));

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pins       = r_pins;
        n_valid      = r_valid;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out        = r_out;
        w_push       = 1'b0;
        w_we         = 1'b0;
        w_raddr      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pins  = i_in.data.pin_levels;
                    n_idx   = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_stall) begin
                    w_raddr = r_idx;
                end else begin
                    w_raddr        = IW'(r_idx + 1'b1);
                    w_we           = w_en;
                    n_valid[r_idx] = w_en;
                    if (w_en && w_ev_valid) begin
                        if (r_hold_valid) begin
                            w_push = 1'b1;
                            n_out  = r_hold;
                        end
                        n_hold_valid         = 1'b1;
                        n_hold.button_number = 3'(r_idx);
                        n_hold.event_code    = w_ev_code;
                        n_hold.click_count   = w_ev_count;
                        n_hold.last_of_tick  = 1'b0;
                    end
                    if (w_is_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = IW'(r_idx + 1'b1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_push             = 1'b1;
                    n_out              = r_hold;
                    n_out.last_of_tick = 1'b1;
                    n_hold_valid       = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pins <= n_pins;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_valid)
        else $error("pending event left over in idle");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == S_RUN && r_idx == '0)
        else $error("scan did not start at the first button");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> r_hold_valid && r_out_valid && !o_out.ready)
        else $error("scan stalled without a blocked output");

    a_stall_holds_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> r_state == S_RUN && $stable(r_idx))
        else $error("button index moved during a stall");
`endif

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the button event classifier.
//
// Scan ticks are queued by the stimulus block and fed to the block by a
// clocked driver with random gaps. A clocked monitor mirrors the per-button
// state machines at every accepted tick and register write, and compares each
// event the block reports with the oldest predicted one. Phases cover a
// directed sequence, zero thresholds, random button scripts with noise,
// full-scale thresholds and a fully disabled scan.
// ----------------------------------------------------------------------------
module tb_top;
    import bec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BTN = 8;
    localparam int CLICK_LIMIT = 3;
    localparam int DRAIN_CYCLES = 4 * (NUM_BTN + 2);
    localparam int FULL_SCALE_TICKS = 12;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bec_chan_if #(.T(t_in_item))  in_ch ();
    bec_chan_if #(.T(t_out_item)) out_ch ();
    bec_chan_if #(.T(t_cfg_item)) cfg_ch ();

    button_event_classifier #(
        .NUM_BUTTONS(NUM_BTN),
        .CLICK_CAP(CLICK_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg(cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0] pending_ticks [$];
    t_out_item  expected_events [$];
    logic       no_idle = 1'b0;
    int         error_count = 0;
    int         events_checked = 0;
    int         ticks_sent = 0;
    int         reg_writes = 0;
    longint     cycle_count = 0;

    logic [7:0]        cfg_mask;
    logic [7:0]        cfg_active;
    logic [TICK_W-1:0] cfg_short;
    logic [TICK_W-1:0] cfg_long;
    logic [TICK_W-1:0] cfg_hold;
    logic [TICK_W-1:0] cfg_combo;

    t_stage            btn_stage [NUM_BTN];
    logic [TICK_W-1:0] btn_ticks [NUM_BTN];
    int                btn_clicks [NUM_BTN];
    t_event            btn_last [NUM_BTN];

    task automatic flag_error(input string msg);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic clear_button(input int b);
        btn_stage[b] = ST_IDLE;
        btn_ticks[b] = '0;
        btn_clicks[b] = 0;
        btn_last[b] = EV_NONE;
    endtask

    task automatic reset_mirror();
        cfg_mask = 8'h00;
        cfg_active = 8'h00;
        cfg_short = SHORT_TICKS_RST;
        cfg_long = LONG_TICKS_RST;
        cfg_hold = HOLD_TICKS_RST;
        cfg_combo = COMBO_WINDOW_RST;
        for (int b = 0; b < NUM_BTN; b++) clear_button(b);
    endtask

    task automatic apply_reg_write(input logic [REG_IDX_W-1:0] idx,
                                   input logic [TICK_W-1:0] value);
        case (idx)
            REG_ENABLED_MASK:  cfg_mask = value[7:0];
            REG_ACTIVE_LEVELS: cfg_active = value[7:0];
            REG_SHORT_TICKS:   cfg_short = value;
            REG_LONG_TICKS:    cfg_long = value;
            REG_HOLD_TICKS:    cfg_hold = value;
            REG_COMBO_WINDOW:  cfg_combo = value;
            default: ;
        endcase
    endtask

    // Advances every enabled button by one scan tick, clears the disabled ones and queues the events they raise.
    task automatic classify_tick(input logic [7:0] pins);
        t_out_item found [$];
        t_out_item item;
        t_event    ev;
        int        cnt;
        logic      pressed;
        for (int b = 0; b < NUM_BTN; b++) begin
            if (b >= 8 || !cfg_mask[b]) begin
                clear_button(b);
                continue;
            end
            pressed = (pins[b] == cfg_active[b]);
            ev = EV_NONE;
            cnt = 0;
            if ((btn_stage[b] == ST_DOWN || btn_stage[b] == ST_COMBO)
                    && btn_ticks[b] != TICK_MAX) begin
                btn_ticks[b] = btn_ticks[b] + 1'b1;
            end
            case (btn_stage[b])
                ST_DOWN: begin
                    if (pressed) begin
                        if (btn_clicks[b] > 0) begin
                            if (btn_ticks[b] > cfg_combo) begin
                                ev = EV_CLICK;
                                cnt = btn_clicks[b];
                                btn_ticks[b] = '0;
                                btn_clicks[b] = 0;
                            end
                        end else if (btn_ticks[b] >= cfg_hold) begin
                            if (btn_last[b] != EV_HOLD) ev = EV_HOLD;
                        end else if (btn_ticks[b] >= cfg_long) begin
                            if (btn_last[b] != EV_LONG) ev = EV_LONG;
                        end else if (btn_ticks[b] >= cfg_short) begin
                            if (btn_last[b] != EV_SHORT) ev = EV_SHORT;
                        end
                    end else if (btn_ticks[b] >= cfg_hold) begin
                        ev = EV_HOLD_UP;
                        btn_stage[b] = ST_IDLE;
                    end else if (btn_ticks[b] >= cfg_long) begin
                        ev = EV_LONG_UP;
                        btn_stage[b] = ST_IDLE;
                    end else if (btn_ticks[b] >= cfg_short) begin
                        ev = EV_SHORT_UP;
                        btn_stage[b] = ST_IDLE;
                    end else begin
                        btn_stage[b] = ST_COMBO;
                        if (btn_clicks[b] < CLICK_LIMIT) btn_clicks[b]++;
                        ev = EV_RELEASE;
                    end
                end
                ST_COMBO: begin
                    if (pressed) begin
                        btn_stage[b] = ST_DOWN;
                        btn_ticks[b] = '0;
                    end else if (btn_ticks[b] > cfg_combo) begin
                        ev = EV_CLICK;
                        cnt = btn_clicks[b];
                        btn_stage[b] = ST_IDLE;
                    end
                end
                default: begin
                    btn_ticks[b] = '0;
                    if (pressed) begin
                        btn_clicks[b] = 0;
                        ev = EV_DOWN;
                        btn_stage[b] = ST_DOWN;
                    end
                end
            endcase
            if (ev != EV_NONE) begin
                btn_last[b] = ev;
                item.button_number = 3'(b);
                item.event_code = ev;
                item.click_count = 2'(cnt);
                item.last_of_tick = 1'b0;
                found.push_back(item);
            end
        end
        if (found.size() > 0) found[found.size() - 1].last_of_tick = 1'b1;
        foreach (found[k]) expected_events.push_back(found[k]);
    endtask

    // Tick driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_ticks.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= t_in_item'(pending_ticks.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Event sink back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    // Monitor: mirrors the block state and checks every reported event.
    always @(posedge i_clk) begin : monitor
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            reset_mirror();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg_write(cfg_ch.data.reg_index, cfg_ch.data.reg_value);
            end
            if (in_ch.valid && in_ch.ready) begin
                ticks_sent++;
                classify_tick(in_ch.data.pin_levels);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_events.size() == 0) begin
                    flag_error($sformatf("unexpected event: button %0d code %0d count %0d",
                                         got.button_number, got.event_code,
                                         got.click_count));
                end else begin
                    want = expected_events.pop_front();
                    events_checked++;
                    if (got.button_number !== want.button_number)
                        flag_error($sformatf("button_number %0d, expected %0d",
                                             got.button_number, want.button_number));
                    if (got.event_code !== want.event_code)
                        flag_error($sformatf("event_code %0d, expected %0d (button %0d)",
                                             got.event_code, want.event_code,
                                             want.button_number));
                    if (got.click_count !== want.click_count)
                        flag_error($sformatf("click_count %0d, expected %0d (button %0d)",
                                             got.click_count, want.click_count,
                                             want.button_number));
                    if (got.last_of_tick !== want.last_of_tick)
                        flag_error($sformatf("last_of_tick %0b, expected %0b (button %0d)",
                                             got.last_of_tick, want.last_of_tick,
                                             want.button_number));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d events still expected",
                     cycle_count, expected_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || in_ch.valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{reg_index: idx, reg_value: value};
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic program_regs(input logic [7:0] mask, input logic [7:0] active,
                                input int shrt, input int lng, input int hld, input int combo);
        wait_quiet();
        write_reg(REG_ENABLED_MASK, {8'h00, mask});
        write_reg(REG_ACTIVE_LEVELS, {8'h00, active});
        write_reg(REG_SHORT_TICKS, TICK_W'(shrt));
        write_reg(REG_LONG_TICKS, TICK_W'(lng));
        write_reg(REG_HOLD_TICKS, TICK_W'(hld));
        write_reg(REG_COMBO_WINDOW, TICK_W'(combo));
    endtask

    function automatic int press_length(input int shrt, input int lng, input int hld);
        int len;
        case ($urandom_range(4))
            0, 4: len = (shrt > 1) ? $urandom_range(1, shrt - 1) : 1;
            1: len = $urandom_range(shrt, lng);
            2: len = $urandom_range(lng, hld);
            default: len = hld + $urandom_range(0, 3);
        endcase
        return (len < 1) ? 1 : len;
    endfunction

    function automatic int gap_length(input int combo);
        int len;
        len = $urandom_range(1) ? $urandom_range(1, combo) : combo + $urandom_range(1, 4);
        return (len < 1) ? 1 : len;
    endfunction

    // Each button follows its own script of presses and gaps sized around the
    // thresholds; some ticks get one pin flipped as noise.
    task automatic queue_scripted(input int count, input int noise_pct,
                                  input logic [7:0] active, input int shrt,
                                  input int lng, input int hld, input int combo);
        int         left [NUM_BTN];
        logic [7:0] held;
        logic [7:0] pins;
        int         bit_pos;
        held = 8'($urandom);
        foreach (left[b]) left[b] = $urandom_range(0, 2);
        @(negedge i_clk);
        for (int k = 0; k < count; k++) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                if (left[b] <= 0) begin
                    held[b] = ~held[b];
                    left[b] = held[b] ? press_length(shrt, lng, hld) : gap_length(combo);
                end
                left[b]--;
            end
            pins = ~(held ^ active);
            if ($urandom_range(99) < noise_pct) begin
                bit_pos = $urandom_range(7);
                pins[bit_pos] = ~pins[bit_pos];
            end
            pending_ticks.push_back(pins);
        end
    endtask

    // Short fixed sequence: single tap, four quick taps past the click cap,
    // short, long and hold presses, a click raised while held, a late press and repeated presses.
    task automatic queue_planned(input logic [7:0] active);
        logic [23:0] plan [NUM_BTN];
        logic [7:0]  held;
        plan = '{24'h000001, 24'h000055, 24'h0001FF, 24'h000007,
                 24'h00001F, 24'h001FFD, 24'hFFFC00, 24'h0F0F0F};
        @(negedge i_clk);
        for (int k = 0; k < 24; k++) begin
            for (int b = 0; b < NUM_BTN; b++) held[b] = plan[b][k];
            pending_ticks.push_back(~(held ^ active));
        end
    endtask

    initial begin : stimulus
        logic [7:0] mask;
        logic [7:0] active;
        int         shrt;
        int         lng;
        int         hld;
        int         combo;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(8'hFF, 8'h0F, 2, 4, 6, 2);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'(TICK_W'($urandom)));
        queue_planned(8'h0F);

        // Zero thresholds, with half the buttons disabled.
        program_regs(8'hA5, 8'hFF, 0, 0, 0, 0);
        queue_scripted(30, 10, 8'hFF, 0, 0, 0, 0);

        for (int p = 0; p < 4; p++) begin
            mask = (p == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            active = 8'($urandom);
            shrt = $urandom_range(1, 4);
            lng = shrt + $urandom_range(1, 6);
            hld = lng + $urandom_range(1, 8);
            combo = $urandom_range(1, 5);
            program_regs(mask, active, shrt, lng, hld, combo);
            no_idle = (p == 2);
            queue_scripted(36, 12, active, shrt, lng, hld, combo);
        end

        // One button held under a long threshold of 65000 and a full-scale hold threshold; another
        // left in its combo window, which can never expire at full scale.
        program_regs(8'h03, 8'h00, 3, 65000, int'(TICK_MAX), int'(TICK_MAX));
        no_idle = 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < FULL_SCALE_TICKS; k++) begin
            pending_ticks.push_back((k == 0) ? 8'hFC : 8'hFE);
        end
        repeat (3) pending_ticks.push_back(8'hFF);

        program_regs(8'h00, 8'hFF, 5, 10, 20, 5);
        no_idle = 1'b0;
        queue_scripted(6, 50, 8'hFF, 5, 10, 20, 5);

        wait_quiet();
        $display("Run summary: %0d scan ticks, %0d events checked, %0d register writes.",
                 ticks_sent, events_checked, reg_writes);
        $display("Covered zero and full-scale thresholds, click cap, %s",
                 "disabled buttons and ignored register indexes.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
design/bec_pkg.sv
design/bec_chan_if.sv
design/bec_ram.sv
design/bec_cfg_regs.sv
design/bec_button_unit.sv
design/button_event_classifier.sv
verif/tb_top.sv
